// ===== design/psup_pkg.sv =====
package psup_pkg;

  localparam int unsigned TempW    = 8;
  localparam int unsigned AdcW     = 12;
  localparam int unsigned VoltW    = 16;
  localparam int unsigned CurW     = 8;
  localparam int unsigned CodeW    = 4;
  localparam int unsigned DigitW   = 3;
  localparam int unsigned LedW     = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;

  // shared iteration length: one quotient bit or one binary bit per cycle
  localparam int unsigned DivSteps = 16;
  localparam int unsigned StepCntW = $clog2(DivSteps);
  localparam int unsigned BcdW     = 20;

  localparam logic [7:0] LabelEnd  = 8'd100;
  localparam logic [7:0] CycleEnd  = 8'd200;
  localparam logic [5:0] BeatTicks = 6'd50;

  localparam logic [CodeW-1:0] CodeBlank = 4'd15;
  localparam logic [CodeW-1:0] CodeP     = 4'd14;
  localparam logic [CodeW-1:0] CodeL     = 4'd13;
  localparam logic [CodeW-1:0] CodeDash  = 4'd10;
  localparam logic [CodeW-1:0] CodeNone  = 4'd0;

  localparam logic [DigitW-1:0] DigitNone = 3'd0;
  localparam logic [DigitW-1:0] DigitTens = 3'd3;

  localparam logic [CurW-1:0] ClipMax = 8'd255;

  localparam logic [CfgIdxW-1:0] RegFanOn    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFanOff   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCurOfs   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegCurSens  = 2'd3;

  localparam logic [CodeW-1:0] VoltLabel [4] = '{CodeBlank, CodeBlank, CodeP, CodeDash};

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// ===== design/psup_div.sv =====
module psup_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [psup_pkg::VoltW-1:0]    dividend_i,
  input  logic [psup_pkg::AdcW-1:0]     divisor_i,
  output psup_pkg::unit_status_t        status_o,
  output logic [psup_pkg::VoltW-1:0]    quot_o
);
  import psup_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic [AdcW-1:0]     rem_q, rem_d;
  logic [VoltW-1:0]    quo_q, quo_d;
  logic [AdcW-1:0]     dsr_q, dsr_d;
  logic [AdcW:0]       trial;
  logic [AdcW:0]       diff;
  logic                geq;

  // one restoring step per cycle, quotient shifts into the dividend register
  always_comb begin
    trial = {rem_q, quo_q[VoltW-1]};
    diff  = trial - {1'b0, dsr_q};
    geq   = trial >= {1'b0, dsr_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = geq ? diff[AdcW-1:0] : trial[AdcW-1:0];
      quo_d = {quo_q[VoltW-2:0], geq};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == StepCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quo_q;

`ifndef ASSERT_OFF
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a run");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (dsr_q != '0) |-> rem_q < dsr_q)
    else $error("divider remainder out of range");
`endif

endmodule

// ===== design/psup_bcd.sv =====
module psup_bcd (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [psup_pkg::VoltW-1:0]    value_i,
  output psup_pkg::unit_status_t        status_o,
  output logic [psup_pkg::VoltW-1:0]    digits_o
);
  import psup_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic [VoltW-1:0]    bin_q, bin_d;
  logic [BcdW-1:0]     bcd_q, bcd_d;
  logic [BcdW-1:0]     adj;

  // shift-add-3, one binary bit per cycle
  always_comb begin
    for (int i = 0; i < BcdW / 4; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      bin_d  = value_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {adj[BcdW-2:0], bin_q[VoltW-1]};
      bin_d = {bin_q[VoltW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == StepCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign digits_o      = bcd_q[VoltW-1:0];

endmodule

// ===== design/power_unit_supervisor_tick.sv =====
// an accepted request starts the divider and the converter; the results follow once the divider is done
// a tick gives one result (wrap or current label) or four, one per cycle unless the output stalls
// the 16-step restoring divider and the 16-step shift-add-3 converter run on every tick
// both run side by side from the accept edge; no new request is taken until the last result
// reset: thresholds 80/70, offset 2048, sensitivity 41, counters and fan and heartbeat cleared
module power_unit_supervisor_tick (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [psup_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [psup_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             estop_left_i,
  input  logic                             estop_right_i,
  input  logic                             mc_interlock_i,
  input  logic                             glv_master_i,
  input  logic                             bms_fault_i,
  input  logic                             imd_fault_i,
  input  logic [psup_pkg::TempW-1:0]       mc_temp_i,
  input  logic [psup_pkg::VoltW-1:0]       pack_volts_i,
  input  logic [psup_pkg::AdcW-1:0]        load_current_raw_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             fan_on_o,
  output logic                             ts_fault_o,
  output logic [psup_pkg::LedW-1:0]        shutdown_leds_o,
  output logic                             heartbeat_led_o,
  output logic [psup_pkg::CurW-1:0]        load_tenths_o,
  output logic                             disp_valid_o,
  output logic [psup_pkg::DigitW-1:0]      disp_digit_o,
  output logic [psup_pkg::CodeW-1:0]       disp_code_o,
  output logic                             last_o
);
  import psup_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SCalc = 2'd1;
  localparam logic [1:0] SOut  = 2'd2;

  localparam logic [1:0] KLabel  = 2'd0;
  localparam logic [1:0] KNumber = 2'd1;
  localparam logic [1:0] KWrap   = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [TempW-1:0] fan_on_q, fan_off_q;
  logic [AdcW-1:0]  cur_ofs_q, cur_sens_q;
  logic [7:0]       cycle_q, cycle_d;
  logic             show_volt_q, show_volt_d;
  logic             fan_q, fan_d;
  logic [5:0]       beat_cnt_q, beat_cnt_d;
  logic             beat_q, beat_d;
  logic [1:0]       idx_q, idx_d;

  logic [1:0]       kind_q;
  logic             mode_volt_q;
  logic             pos_q;
  logic             fault_q;
  logic [LedW-1:0]  leds_q;
  logic [CurW-1:0]  cur_q;

  logic             in_acc, out_acc;
  logic [7:0]       cyc_inc;
  logic [5:0]       beat_inc;
  logic [1:0]       kind_d;
  logic [AdcW:0]    delta;
  logic             pos_d;
  logic [VoltW-1:0] dividend;
  logic [VoltW-1:0] bcd_value;
  logic [VoltW-1:0] quot;
  logic [VoltW-1:0] bcd_digits;
  unit_status_t     div_st, bcd_st;
  logic             last_res;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_comb begin
    cyc_inc  = cycle_q + 8'd1;
    beat_inc = beat_cnt_q + 6'd1;
    if (cyc_inc < LabelEnd) begin
      kind_d = KLabel;
    end else if (cyc_inc < CycleEnd) begin
      kind_d = KNumber;
    end else begin
      kind_d = KWrap;
    end
    delta     = {1'b0, load_current_raw_i} - {1'b0, cur_ofs_q};
    pos_d     = !delta[AdcW] && (delta[AdcW-1:0] != '0);
    dividend  = {1'b0, delta[AdcW-1:0], 3'b000} + {3'b000, delta[AdcW-1:0], 1'b0};
    bcd_value = show_volt_q ? pack_volts_i : {{(VoltW-AdcW){1'b0}}, load_current_raw_i};
  end

  psup_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .dividend_i (dividend),
    .divisor_i  (cur_sens_q),
    .status_o   (div_st),
    .quot_o     (quot)
  );

  psup_bcd u_bcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc),
    .value_i  (bcd_value),
    .status_o (bcd_st),
    .digits_o (bcd_digits)
  );

  always_comb begin
    state_d     = state_q;
    cycle_d     = cycle_q;
    show_volt_d = show_volt_q;
    fan_d       = fan_q;
    beat_cnt_d  = beat_cnt_q;
    beat_d      = beat_q;
    idx_d       = idx_q;
    case (state_q)
      SIdle: begin
        if (in_acc) begin
          state_d = SCalc;
          if (kind_d == KWrap) begin
            cycle_d     = '0;
            show_volt_d = !show_volt_q;
          end else begin
            cycle_d = cyc_inc;
          end
          if (mc_temp_i >= fan_on_q) begin
            fan_d = 1'b1;
          end else if (mc_temp_i <= fan_off_q) begin
            fan_d = 1'b0;
          end
          if (beat_inc >= BeatTicks) begin
            beat_cnt_d = '0;
            beat_d     = !beat_q;
          end else begin
            beat_cnt_d = beat_inc;
          end
        end
      end
      SCalc: begin
        if (div_st.done) begin
          state_d = SOut;
          idx_d   = '0;
        end
      end
      SOut: begin
        if (out_acc) begin
          if (last_res) begin
            state_d = SIdle;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      fan_on_q    <= 8'd80;
      fan_off_q   <= 8'd70;
      cur_ofs_q   <= 12'd2048;
      cur_sens_q  <= 12'd41;
      cycle_q     <= '0;
      show_volt_q <= 1'b1;
      fan_q       <= 1'b0;
      beat_cnt_q  <= '0;
      beat_q      <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      cycle_q     <= cycle_d;
      show_volt_q <= show_volt_d;
      fan_q       <= fan_d;
      beat_cnt_q  <= beat_cnt_d;
      beat_q      <= beat_d;
      idx_q       <= idx_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegFanOn:   fan_on_q   <= cfg_wdata_i[TempW-1:0];
          RegFanOff:  fan_off_q  <= cfg_wdata_i[TempW-1:0];
          RegCurOfs:  cur_ofs_q  <= cfg_wdata_i[AdcW-1:0];
          RegCurSens: cur_sens_q <= cfg_wdata_i[AdcW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // request fields held for the whole tick
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q      <= kind_d;
      mode_volt_q <= show_volt_q;
      pos_q       <= pos_d;
      fault_q     <= bms_fault_i | imd_fault_i;
      leds_q      <= {glv_master_i, mc_interlock_i, estop_right_i, estop_left_i};
    end
    if (state_q == SCalc && div_st.done) begin
      if (!pos_q) begin
        cur_q <= '0;
      end else if (quot[VoltW-1:CurW] != '0) begin
        cur_q <= ClipMax;
      end else begin
        cur_q <= quot[CurW-1:0];
      end
    end
  end

  always_comb begin
    last_res     = (kind_q == KWrap) || (kind_q == KLabel && !mode_volt_q) || (idx_q == 2'd3);
    disp_valid_o = kind_q != KWrap;
    disp_digit_o = {1'b0, idx_q} + 3'd1;
    disp_code_o  = CodeNone;
    case (kind_q)
      KLabel: begin
        if (mode_volt_q) begin
          disp_code_o = VoltLabel[idx_q];
        end else begin
          disp_digit_o = DigitTens;
          disp_code_o  = CodeL;
        end
      end
      KNumber: begin
        disp_code_o = bcd_digits[{~idx_q, 2'b00} +: CodeW];
      end
      default: begin
        disp_digit_o = DigitNone;
        disp_code_o  = CodeNone;
      end
    endcase
  end

  assign in_stall_o      = state_q != SIdle;
  assign out_valid_o     = state_q == SOut;
  assign last_o          = last_res;
  assign fan_on_o        = fan_q;
  assign ts_fault_o      = fault_q;
  assign shutdown_leds_o = leds_q;
  assign heartbeat_led_o = beat_q;
  assign load_tenths_o   = cur_q;

`ifndef ASSERT_OFF
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !out_valid_o)
    else $error("result before units finished");
  a_units_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> bcd_st.done)
    else $error("divider and converter out of step");
  a_wrap_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !disp_valid_o |-> last_o && (disp_digit_o == DigitNone))
    else $error("wrap tick gave more than one result");
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && disp_valid_o |-> (disp_digit_o >= 3'd1) && (disp_digit_o <= 3'd4))
    else $error("digit position out of range");
  a_cycle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cycle_q < CycleEnd)
    else $error("display cycle counter overran");
`endif

endmodule
